// File: sv/owse_pkg.sv
// ----------------------------------------------------------------------------
// owse_pkg: shared types and constants for the 1-Wire slave engine
// Bus modes, command codes, register indexes and the front/back item struct.
// ----------------------------------------------------------------------------
package owse_pkg;

  typedef enum logic [2:0] {
    M_IDLE     = 3'd0,
    M_RESET    = 3'd1,
    M_PRESENCE = 3'd2,
    M_COMMAND  = 3'd3,
    M_MATCH    = 3'd4,
    M_SEARCH   = 3'd5,
    M_WRITE    = 3'd6,
    M_READ     = 3'd7
  } mode_t;

  localparam logic [7:0] CMD_MATCH  = 8'h55;
  localparam logic [7:0] CMD_SEARCH = 8'hF0;
  localparam logic [7:0] CMD_WRITE  = 8'h4E;
  localparam logic [7:0] CMD_READ   = 8'hBE;
  localparam logic [7:0] CRC_POLY   = 8'h8C;

  localparam logic [2:0] REG_ROM_ID         = 3'd0;
  localparam logic [2:0] REG_RESET_MIN      = 3'd1;
  localparam logic [2:0] REG_SAMPLE_DELAY   = 3'd2;
  localparam logic [2:0] REG_LOW_TIME       = 3'd3;
  localparam logic [2:0] REG_PRESENCE       = 3'd4;
  localparam logic [2:0] REG_PRESENCE_DELAY = 3'd5;

  localparam logic [7:0] RESET_MIN_DEFAULT = 8'd40;
  localparam logic [7:0] PRESENCE_DEFAULT  = 8'd20;

  // one sampled tick after classification
  typedef struct packed {
    logic        level;
    logic        falling;
    logic [63:0] src;
  } tick_t;

endpackage

// File: sv/owse_front.sv
// ----------------------------------------------------------------------------
// owse_front: input side
// Accepts sampled line levels and marks falling edges.
// ----------------------------------------------------------------------------
module owse_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 level,
  input  logic [63:0]          src,
  output logic                 q_push,
  output owse_pkg::tick_t      q_data,
  input  logic                 q_full
);
  logic prev_level_r;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;
  assign q_data   = '{level: level, falling: prev_level_r && !level, src: src};

  // edge detect tracks accepted items only
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r <= 1'b1;
    end else if (q_push) begin
      prev_level_r <= level;
    end
  end
endmodule

// File: sv/owse_queue.sv
// ----------------------------------------------------------------------------
// owse_queue: two-entry queue between front and back
// Lets the input and the engine stall independently.
// ----------------------------------------------------------------------------
module owse_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  owse_pkg::tick_t      push_data,
  output logic                 full,
  input  logic                 pop,
  output owse_pkg::tick_t      pop_data,
  output logic                 not_empty
);
  owse_pkg::tick_t mem_r [2];
  logic            wp_r, rp_r;
  logic [1:0]      cnt_r;

  assign full      = cnt_r == 2'd2;
  assign not_empty = cnt_r != 2'd0;
  assign pop_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !not_empty |-> !pop) else $error("queue underflow");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2) else $error("queue count out of range");
endmodule

// File: sv/owse_back.sv
// ----------------------------------------------------------------------------
// owse_back: protocol engine
// Runs the reset/presence/slot state machine, one tick per item, into an
// output register.
// ----------------------------------------------------------------------------
module owse_back #(
  parameter int DATA_BYTES = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  owse_pkg::tick_t      q_data,
  input  logic [63:0]          rom_id,
  input  logic [7:0]           reset_min,
  input  logic [3:0]           sample_delay,
  input  logic [3:0]           low_time,
  input  logic [7:0]           presence_len,
  input  logic [3:0]           presence_delay,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          out_data
);
  localparam logic [3:0] LAST_BYTE = 4'(DATA_BYTES);
  localparam logic [3:0] CRC_BYTES = 4'(DATA_BYTES - 1);

  owse_pkg::mode_t mode_r, mode_nxt;
  logic [7:0]  tick_r, tick_nxt, low_run_r, low_run_nxt, shift_r, shift_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic [3:0]  byte_r, byte_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic        send_r, send_nxt;
  logic [63:0] latch_r, latch_nxt;
  logic        ov_r;
  logic [31:0] od_r, od_nxt;

  logic        o_drive, o_cv, o_wv, o_rd;
  logic [7:0]  o_cb, o_wb;
  logic [3:0]  o_wi;

  assign q_pop     = q_valid && (!ov_r || out_ready);
  assign out_valid = ov_r;
  assign out_data  = od_r;

  function automatic logic pick(input logic [63:0] w, input logic [3:0] by,
                                input logic [2:0] bi);
    return w[{by[2:0], bi}];
  endfunction

  always_comb begin
    logic lv, sending, done, rb;
    logic [7:0] d, sh;
    lv = q_data.level;
    mode_nxt = mode_r; tick_nxt = tick_r; low_run_nxt = low_run_r;
    shift_nxt = shift_r; crc_nxt = crc_r; bit_nxt = bit_r; byte_nxt = byte_r;
    phase_nxt = phase_r; send_nxt = send_r; latch_nxt = latch_r;
    o_drive = 1'b0; o_cv = 1'b0; o_cb = '0; o_wv = 1'b0; o_wi = '0; o_wb = '0;
    o_rd = 1'b0; sending = 1'b0; done = 1'b0; rb = 1'b0; d = '0; sh = '0;

    // low run and reset detection
    if (mode_r == owse_pkg::M_PRESENCE) low_run_nxt = '0;
    else if (!lv) low_run_nxt = (low_run_r == 8'hFF) ? low_run_r : low_run_r + 8'd1;
    else low_run_nxt = '0;
    if (mode_r != owse_pkg::M_PRESENCE && !lv && low_run_nxt >= reset_min) begin
      mode_nxt = owse_pkg::M_RESET; phase_nxt = '0; tick_nxt = '0;
    end

    unique case (mode_nxt)
      owse_pkg::M_IDLE: ;
      owse_pkg::M_RESET: begin
        if (phase_nxt == 2'd0) begin
          if (lv) begin phase_nxt = 2'd1; tick_nxt = {4'd0, presence_delay}; end
        end else begin
          if (tick_nxt > 8'd1 && tick_nxt != '0) tick_nxt = tick_nxt - 8'd1;
          else begin
            // delay over: presence starts and runs its first tick
            mode_nxt = owse_pkg::M_PRESENCE; phase_nxt = '0; o_drive = 1'b1;
            if (presence_len <= 8'd1) begin
              mode_nxt = owse_pkg::M_COMMAND; tick_nxt = '0; bit_nxt = '0; shift_nxt = '0;
            end else tick_nxt = presence_len - 8'd1;
          end
        end
      end
      owse_pkg::M_PRESENCE: begin
        o_drive = 1'b1;
        if (tick_nxt <= 8'd1) begin
          mode_nxt = owse_pkg::M_COMMAND; tick_nxt = '0; bit_nxt = '0; shift_nxt = '0;
        end else tick_nxt = tick_nxt - 8'd1;
      end
      default: begin
        sending = (mode_nxt == owse_pkg::M_READ) ||
                  (mode_nxt == owse_pkg::M_SEARCH && phase_nxt < 2'd2);
        d = {4'd0, sending ? low_time : sample_delay};
        if (d == '0) d = 8'd1;
        if (q_data.falling) tick_nxt = d;
        else if (tick_nxt != '0) begin
          tick_nxt = tick_nxt - 8'd1;
          if (tick_nxt == '0) begin
            // slot end
            done = (bit_nxt == 3'd7);
            unique case (mode_nxt)
              owse_pkg::M_COMMAND: begin
                sh = shift_nxt | (8'(lv) << bit_nxt);
                bit_nxt = bit_nxt + 3'd1;
                shift_nxt = sh;
                if (done) begin
                  byte_nxt = '0; bit_nxt = '0; shift_nxt = '0;
                  unique case (sh)
                    owse_pkg::CMD_MATCH: mode_nxt = owse_pkg::M_MATCH;
                    owse_pkg::CMD_SEARCH: begin
                      mode_nxt = owse_pkg::M_SEARCH; phase_nxt = '0;
                      send_nxt = rom_id[0];
                    end
                    owse_pkg::CMD_WRITE: mode_nxt = owse_pkg::M_WRITE;
                    owse_pkg::CMD_READ: begin
                      mode_nxt = owse_pkg::M_READ; latch_nxt = q_data.src;
                      crc_nxt = '0; send_nxt = q_data.src[0];
                    end
                    default: begin
                      o_cv = 1'b1; o_cb = sh; mode_nxt = owse_pkg::M_IDLE;
                    end
                  endcase
                end
              end
              owse_pkg::M_MATCH: begin
                if (lv != pick(rom_id, byte_nxt, bit_nxt)) mode_nxt = owse_pkg::M_IDLE;
                else begin
                  bit_nxt = bit_nxt + 3'd1;
                  if (done) begin
                    if (byte_nxt >= 4'd7) begin
                      mode_nxt = owse_pkg::M_COMMAND; byte_nxt = '0; shift_nxt = '0;
                    end else byte_nxt = byte_nxt + 4'd1;
                  end
                end
              end
              owse_pkg::M_SEARCH: begin
                if (phase_nxt == 2'd0) begin
                  phase_nxt = 2'd1; send_nxt = !send_nxt;
                end else if (phase_nxt == 2'd1) phase_nxt = 2'd2;
                else if (lv != pick(rom_id, byte_nxt, bit_nxt)) mode_nxt = owse_pkg::M_IDLE;
                else begin
                  bit_nxt = bit_nxt + 3'd1;
                  if (done && byte_nxt >= 4'd7) mode_nxt = owse_pkg::M_IDLE;
                  else begin
                    if (done) byte_nxt = byte_nxt + 4'd1;
                    phase_nxt = '0; send_nxt = pick(rom_id, byte_nxt, bit_nxt);
                  end
                end
              end
              owse_pkg::M_WRITE: begin
                sh = shift_nxt | (8'(lv) << bit_nxt);
                bit_nxt = bit_nxt + 3'd1; shift_nxt = sh;
                if (done) begin
                  o_wv = 1'b1; o_wi = byte_nxt; o_wb = sh; shift_nxt = '0;
                  if (byte_nxt >= LAST_BYTE) mode_nxt = owse_pkg::M_IDLE;
                  else byte_nxt = byte_nxt + 4'd1;
                end
              end
              owse_pkg::M_READ: begin
                if (byte_nxt < CRC_BYTES)
                  crc_nxt = (crc_nxt[0] != send_nxt) ? ((crc_nxt >> 1) ^ owse_pkg::CRC_POLY)
                                                     : (crc_nxt >> 1);
                bit_nxt = bit_nxt + 3'd1;
                rb = 1'b1;
                if (done) begin
                  if (byte_nxt == '0) o_rd = 1'b1;
                  if (byte_nxt >= LAST_BYTE) begin mode_nxt = owse_pkg::M_IDLE; rb = 1'b0; end
                  else byte_nxt = byte_nxt + 4'd1;
                end
                if (rb) send_nxt = (byte_nxt < LAST_BYTE) ? pick(latch_nxt, byte_nxt, bit_nxt)
                                                           : crc_nxt[bit_nxt];
              end
              default: ;
            endcase
          end
        end
        if (sending && tick_nxt != '0 && !send_nxt) o_drive = 1'b1;
      end
    endcase
    od_nxt = {5'd0, o_rd, o_wb, o_wi, o_wv, o_cb, o_cv, mode_nxt, o_drive};
  end

  // engine state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= owse_pkg::M_IDLE; tick_r <= '0; low_run_r <= '0; shift_r <= '0;
      crc_r <= '0; bit_r <= '0; byte_r <= '0; phase_r <= '0; send_r <= 1'b0;
      latch_r <= '0; ov_r <= 1'b0;
    end else begin
      if (q_pop) begin
        mode_r <= mode_nxt; tick_r <= tick_nxt; low_run_r <= low_run_nxt;
        shift_r <= shift_nxt; crc_r <= crc_nxt; bit_r <= bit_nxt; byte_r <= byte_nxt;
        phase_r <= phase_nxt; send_r <= send_nxt; latch_r <= latch_nxt;
        od_r <= od_nxt; ov_r <= 1'b1;
      end else if (out_ready) ov_r <= 1'b0;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready) |=> $stable(od_r)) else $error("result changed while stalled");
  a_write_idx: assert property (@(posedge clk) disable iff (!rst_n)
    !(ov_r && od_r[13] && od_r[17:14] > LAST_BYTE)) else $error("write index range");
  a_presence_drive: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && od_r[3:1] == owse_pkg::M_PRESENCE) |-> od_r[0]) else $error("presence drive");
endmodule

// File: sv/one_wire_slave_engine.sv
// ----------------------------------------------------------------------------
// one_wire_slave_engine: 1-Wire slave fed one line sample per tick
// Front end classifies edges, queue decouples, back end runs the protocol.
// ----------------------------------------------------------------------------
// channel | dir | payload
// in_     | in  | tdata: line_level[0], scratch_source[64:1]
// out_    | out | tdata: drive_low, bus_state, command_valid/byte, write_*, read_done
// cfg_    | in  | write-only register port, index 0..5
// One item per cycle sustained while out_tready holds; items pass through the queue
// and the output register. The back-end state update for one tick sets the rate.
// rst_n is synchronous; all control state clears. Either side may stall;
// a two-entry queue and the output register absorb it.
// ----------------------------------------------------------------------------
module one_wire_slave_engine #(
  parameter int DATA_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // line_level[0], scratch_source[64:1], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // drive_low[0], bus_state[3:1], command_valid[4],
                                  // command_byte[12:5], write_valid[13],
                                  // write_index[17:14], write_byte[25:18],
                                  // read_done[26], zero pad
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);
  logic [63:0] rom_r;
  logic [7:0]  rmin_r, pres_r;
  logic [3:0]  sd_r, lt_r, pd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_r <= '0; rmin_r <= owse_pkg::RESET_MIN_DEFAULT; sd_r <= 4'd3; lt_r <= 4'd3;
      pres_r <= owse_pkg::PRESENCE_DEFAULT; pd_r <= 4'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        owse_pkg::REG_ROM_ID:         rom_r  <= cfg_wdata;
        owse_pkg::REG_RESET_MIN:      rmin_r <= cfg_wdata[7:0];
        owse_pkg::REG_SAMPLE_DELAY:   sd_r   <= cfg_wdata[3:0];
        owse_pkg::REG_LOW_TIME:       lt_r   <= cfg_wdata[3:0];
        owse_pkg::REG_PRESENCE:       pres_r <= cfg_wdata[7:0];
        owse_pkg::REG_PRESENCE_DELAY: pd_r   <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  owse_pkg::tick_t qi, qo;
  logic push, full, pop, ne;

  owse_front u_front (.clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
    .level(in_tdata[0]), .src(in_tdata[64:1]), .q_push(push), .q_data(qi), .q_full(full));
  owse_queue u_queue (.clk, .rst_n, .push, .push_data(qi), .full, .pop,
    .pop_data(qo), .not_empty(ne));
  owse_back #(.DATA_BYTES(DATA_BYTES)) u_back (.clk, .rst_n, .q_valid(ne), .q_pop(pop),
    .q_data(qo), .rom_id(rom_r), .reset_min(rmin_r), .sample_delay(sd_r),
    .low_time(lt_r), .presence_len(pres_r), .presence_delay(pd_r),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_data(out_tdata));
endmodule
